// ===== rtl/core/hbs_pkg.sv =====
// shared types and constants of the heightmap bilinear sampler
package hbs_pkg;

  // largest tile side and derived store geometry
  localparam int MaxSide = 256;
  localparam int SideW   = $clog2(MaxSide + 1);
  localparam int CoordW  = $clog2(MaxSide);
  localparam int Depth   = MaxSide * MaxSide;
  localparam int AddrW   = $clog2(Depth);

  // field and register widths
  localparam int DimW    = 9;
  localparam int GainW   = 16;
  localparam int PosW    = 16;
  localparam int HeightW = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgTileWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTileHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHeightGain = 2'd2;

  // item kinds
  localparam logic KindLoad   = 1'b0;
  localparam logic KindSample = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    StIdle,
    StLoadWr,
    StCoord,
    StCorner,
    StFlush,
    StDone
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       capture;
    logic       ld_write;
    logic       coord;
    logic       rd_en;
    logic [1:0] corner;
    logic       out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic tile_ready;
  } dp_sts_t;

endpackage

// ===== rtl/core/hbs_if.sv =====
// stream interfaces for input items and result items
interface hbs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [7:0]                   red;
  logic [7:0]                   green;
  logic [7:0]                   blue;
  logic signed [hbs_pkg::PosW-1:0] pos_x;
  logic signed [hbs_pkg::PosW-1:0] pos_y;

  modport source (output valid, kind, red, green, blue, pos_x, pos_y, input ready);
  modport sink (input valid, kind, red, green, blue, pos_x, pos_y, output ready);
endinterface

interface hbs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [hbs_pkg::HeightW-1:0] height;
  logic                               tile_ready;

  modport source (output valid, height, tile_ready, input ready);
  modport sink (input valid, height, tile_ready, output ready);
endinterface

// ===== rtl/core/hbs_ctrl.sv =====
// controller state machine sequencing loads and four-corner samples
module hbs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  hbs_pkg::dp_sts_t sts_i,
  output hbs_pkg::dp_cmd_t cmd_o
);

  hbs_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      hbs_pkg::StIdle: begin
        if (in_valid_i) begin
          if (in_kind_i == hbs_pkg::KindLoad) begin
            state_d = hbs_pkg::StLoadWr;
          end else if (sts_i.tile_ready) begin
            state_d = hbs_pkg::StCoord;
          end else begin
            state_d = hbs_pkg::StDone;
          end
        end
      end
      hbs_pkg::StLoadWr: begin
        state_d = hbs_pkg::StIdle;
      end
      hbs_pkg::StCoord: begin
        state_d = hbs_pkg::StCorner;
        cnt_d   = 2'd0;
      end
      hbs_pkg::StCorner: begin
        if (cnt_q == 2'd3) begin
          state_d = hbs_pkg::StFlush;
          cnt_d   = 2'd0;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      hbs_pkg::StFlush: begin
        if (cnt_q == 2'd1) begin
          state_d = hbs_pkg::StDone;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      hbs_pkg::StDone: begin
        if (out_free) begin
          state_d = hbs_pkg::StIdle;
        end
      end
      default: begin
        state_d = hbs_pkg::StIdle;
      end
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd_o          = '0;
    in_ready_o     = (state_q == hbs_pkg::StIdle);
    cmd_o.capture  = (state_q == hbs_pkg::StIdle) && in_valid_i;
    cmd_o.ld_write = (state_q == hbs_pkg::StLoadWr);
    cmd_o.coord    = (state_q == hbs_pkg::StCoord);
    cmd_o.rd_en    = (state_q == hbs_pkg::StCorner);
    cmd_o.corner   = cnt_q;
    cmd_o.out_load = (state_q == hbs_pkg::StDone) && out_free;
  end

  // result valid flag, held until the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hbs_pkg::StIdle;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sequencing checks
  a_corner_to_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hbs_pkg::StCorner && cnt_q == 2'd3) |=> (state_q == hbs_pkg::StFlush))
    else $error("corner sequence did not end in flush");

  a_load_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hbs_pkg::StLoadWr) |=> (state_q == hbs_pkg::StIdle))
    else $error("load write lasted more than one cycle");

  a_ready_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_kind_i == hbs_pkg::KindSample && sts_i.tile_ready)
    |=> (state_q == hbs_pkg::StCoord))
    else $error("sample on ready tile did not start corner walk");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == hbs_pkg::StDone))
    else $error("result raised outside done state");

endmodule

// ===== rtl/core/hbs_datapath.sv =====
// datapath: config registers, load counters, height store, bilinear blend
module hbs_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hbs_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [hbs_pkg::CfgW-1:0]           cfg_data_i,
  input  logic [7:0]                         red_i,
  input  logic [7:0]                         green_i,
  input  logic [7:0]                         blue_i,
  input  logic signed [hbs_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [hbs_pkg::PosW-1:0]    pos_y_i,
  input  hbs_pkg::dp_cmd_t                   cmd_i,
  output hbs_pkg::dp_sts_t                   sts_o,
  output logic signed [hbs_pkg::HeightW-1:0] height_o,
  output logic                               tile_ready_o
);

  localparam int CmpW = (hbs_pkg::SideW > hbs_pkg::DimW) ? hbs_pkg::SideW : hbs_pkg::DimW;
  localparam int UW   = 16 + hbs_pkg::SideW;
  localparam int IW   = hbs_pkg::SideW + 2;

  // effective side: zero acts as one, large values clamp to the maximum
  function automatic logic [hbs_pkg::SideW-1:0] eff_side(input logic [hbs_pkg::DimW-1:0] v);
    logic [hbs_pkg::SideW-1:0] r;
    if (v == '0) begin
      r = hbs_pkg::SideW'(1);
    end else if (CmpW'(v) > CmpW'(hbs_pkg::MaxSide)) begin
      r = hbs_pkg::SideW'(hbs_pkg::MaxSide);
    end else begin
      r = hbs_pkg::SideW'(v);
    end
    return r;
  endfunction

  // clamp a position to [-1,1] in Q2.14
  function automatic logic signed [hbs_pkg::PosW-1:0] clamp_pos(
    input logic signed [hbs_pkg::PosW-1:0] x
  );
    logic signed [hbs_pkg::PosW-1:0] r;
    if (x < -16'sd16384) begin
      r = -16'sd16384;
    end else if (x > 16'sd16384) begin
      r = 16'sd16384;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // clamp a corner index to the last column or row
  function automatic logic [hbs_pkg::CoordW-1:0] clamp_idx(
    input logic [IW-1:0] i,
    input logic [hbs_pkg::SideW-1:0] side
  );
    logic [IW-1:0] last;
    last = IW'(side) - IW'(1);
    return (i > last) ? hbs_pkg::CoordW'(last) : hbs_pkg::CoordW'(i);
  endfunction

  logic [hbs_pkg::DimW-1:0]  width_q, height_q;
  logic [hbs_pkg::GainW-1:0] gain_q;
  logic [hbs_pkg::SideW-1:0] w_eff, h_eff;
  logic                      dim_write;

  assign w_eff     = eff_side(width_q);
  assign h_eff     = eff_side(height_q);
  assign dim_write = cfg_we_i &&
                     (cfg_idx_i == hbs_pkg::CfgTileWidth || cfg_idx_i == hbs_pkg::CfgTileHeight);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= hbs_pkg::DimW'(256);
      height_q <= hbs_pkg::DimW'(256);
      gain_q   <= hbs_pkg::GainW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hbs_pkg::CfgTileWidth:  width_q  <= cfg_data_i[hbs_pkg::DimW-1:0];
        hbs_pkg::CfgTileHeight: height_q <= cfg_data_i[hbs_pkg::DimW-1:0];
        hbs_pkg::CfgHeightGain: gain_q   <= cfg_data_i[hbs_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  // texel decode and gain multiply at capture
  logic signed [23:0]                e_s;
  logic signed [16:0]                gain_s;
  logic signed [40:0]                ld_prod_d, ld_prod_q;
  logic signed [40:0]                ld_rnd;
  logic [32:0]                       ld_scaled;
  logic signed [hbs_pkg::HeightW-1:0] ld_sat;
  logic signed [hbs_pkg::PosW-1:0]   pos_x_q, pos_y_q;

  assign e_s       = $signed({~red_i[7], red_i[6:0], green_i, blue_i});
  assign gain_s    = $signed({1'b0, gain_q});
  assign ld_prod_d = e_s * gain_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ld_prod_q <= ld_prod_d;
      pos_x_q   <= pos_x_i;
      pos_y_q   <= pos_y_i;
    end
  end

  // round to Q.8 and saturate to 32 bits
  assign ld_rnd    = ld_prod_q + 41'sd128;
  assign ld_scaled = ld_rnd[40:8];
  always_comb begin
    if (ld_scaled[32] == ld_scaled[31]) begin
      ld_sat = $signed(ld_scaled[31:0]);
    end else if (ld_scaled[32]) begin
      ld_sat = {1'b1, {(hbs_pkg::HeightW-1){1'b0}}};
    end else begin
      ld_sat = {1'b0, {(hbs_pkg::HeightW-1){1'b1}}};
    end
  end

  // load pointer as column and row counters, tile ready flag
  logic [hbs_pkg::CoordW-1:0] col_q, row_q;
  logic                       ready_q;
  logic                       col_wrap, row_wrap;

  assign col_wrap = (hbs_pkg::SideW'(col_q) + hbs_pkg::SideW'(1)) == w_eff;
  assign row_wrap = (hbs_pkg::SideW'(row_q) + hbs_pkg::SideW'(1)) == h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      ready_q <= 1'b0;
    end else if (dim_write) begin
      col_q   <= '0;
      row_q   <= '0;
      ready_q <= 1'b0;
    end else if (cmd_i.ld_write) begin
      if (col_wrap) begin
        col_q <= '0;
        if (row_wrap) begin
          row_q   <= '0;
          ready_q <= 1'b1;
        end else begin
          row_q   <= row_q + hbs_pkg::CoordW'(1);
          if (col_q == '0 && row_q == '0) begin
            ready_q <= 1'b0;
          end
        end
      end else begin
        col_q <= col_q + hbs_pkg::CoordW'(1);
        if (col_q == '0 && row_q == '0) begin
          ready_q <= 1'b0;
        end
      end
    end
  end

  assign sts_o.tile_ready = ready_q;

  // texel-space coordinates and corner indices
  logic signed [hbs_pkg::PosW-1:0] cx, cy;
  logic [15:0]                     tu, tv;
  logic [UW-1:0]                   u, v;
  logic [IW-1:0]                   i0_raw, j0_raw;
  logic [hbs_pkg::CoordW-1:0]      i0_q, i1_q, j0_q, j1_q;
  logic [14:0]                     fa_q, fb_q;

  assign cx     = clamp_pos(pos_x_q);
  assign cy     = clamp_pos(pos_y_q);
  assign tu     = 16'(cx + 16'sd16384);
  assign tv     = 16'(16'sd16384 - cy);
  assign u      = UW'(tu) * UW'(w_eff);
  assign v      = UW'(tv) * UW'(h_eff);
  assign i0_raw = IW'(u[UW-1:15]);
  assign j0_raw = IW'(v[UW-1:15]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.coord) begin
      i0_q <= clamp_idx(i0_raw, w_eff);
      i1_q <= clamp_idx(i0_raw + IW'(1), w_eff);
      j0_q <= clamp_idx(j0_raw, h_eff);
      j1_q <= clamp_idx(j0_raw + IW'(1), h_eff);
      fa_q <= u[14:0];
      fb_q <= v[14:0];
    end
  end

  // corner selection and weight
  logic [hbs_pkg::CoordW-1:0] c_col, c_row;
  logic [15:0]                wx, wy;
  logic [31:0]                wgt_full;
  logic [30:0]                wgt_q;

  assign c_col    = cmd_i.corner[0] ? i1_q : i0_q;
  assign c_row    = cmd_i.corner[1] ? j1_q : j0_q;
  assign wx       = cmd_i.corner[0] ? {1'b0, fa_q} : (16'h8000 - {1'b0, fa_q});
  assign wy       = cmd_i.corner[1] ? {1'b0, fb_q} : (16'h8000 - {1'b0, fb_q});
  assign wgt_full = wx * wy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      wgt_q <= wgt_full[30:0];
    end
  end

  // single-port height store
  logic signed [hbs_pkg::HeightW-1:0] mem [hbs_pkg::Depth];
  logic signed [hbs_pkg::HeightW-1:0] rdata_q;
  logic [hbs_pkg::AddrW-1:0]          ld_addr, rd_addr, addr;

  assign ld_addr = hbs_pkg::AddrW'(row_q) * hbs_pkg::AddrW'(hbs_pkg::MaxSide)
                 + hbs_pkg::AddrW'(col_q);
  assign rd_addr = hbs_pkg::AddrW'(c_row) * hbs_pkg::AddrW'(hbs_pkg::MaxSide)
                 + hbs_pkg::AddrW'(c_col);
  assign addr    = cmd_i.ld_write ? ld_addr : rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_write) begin
      mem[addr] <= ld_sat;
    end else if (cmd_i.rd_en) begin
      rdata_q <= mem[addr];
    end
  end

  // multiply-accumulate pipeline over the four corners
  logic                rd_v_q, mul_v_q;
  logic signed [31:0]  wgt_s;
  logic signed [63:0]  prod_q, acc_q, acc_rnd;

  assign wgt_s = $signed({1'b0, wgt_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      rd_v_q  <= cmd_i.rd_en;
      mul_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_q <= rdata_q * wgt_s;
    end
    if (cmd_i.coord) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // round Q.38 to Q.8 and load the result register
  assign acc_rnd = acc_q + 64'sd536870912;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      height_o     <= ready_q ? $signed(acc_rnd[61:30]) : '0;
      tile_ready_o <= ready_q;
    end
  end

endmodule

// ===== rtl/core/heightmap_bilinear_sampler.sv =====
// Heightmap bilinear sampler top level.
// Input channel in_i carries load items (kind 0: one RGB texel, raster order)
// and sample items (kind 1: Q2.14 position). Output channel out_o returns one
// result per sample (Q23.8 height and tile_ready), none per load.
// Configuration is a write port (cfg_we_i, cfg_idx_i, cfg_data_i): index 0
// tile width, 1 tile height, 2 height gain; dimension writes restart loading.
// A load is the transfer, then gain round/saturate and the store write.
// A sample on a ready tile runs through a coordinate step, four corner reads
// through the single-port height store, the multiply-accumulate drain
// (StFlush) and the output register load.
// A sample before the tile is complete skips the corner walk and returns
// zero through the output register load.
// One item is worked on at a time; the next transfer is taken right after.
// Reset restores the register defaults, clears the load pointer and the
// ready flag; the store content is undefined and is not cleared.
// When the receiver stalls, the result waits in the output register while
// loads and the next sample are still taken; that sample holds in its last
// step until the register is free.
module heightmap_bilinear_sampler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hbs_in_if.sink                      in_i,
  hbs_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [hbs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hbs_pkg::CfgW-1:0]    cfg_data_i
);

  hbs_pkg::dp_cmd_t cmd;
  hbs_pkg::dp_sts_t sts;

  // sequencing
  hbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  hbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .red_i       (in_i.red),
    .green_i     (in_i.green),
    .blue_i      (in_i.blue),
    .pos_x_i     (in_i.pos_x),
    .pos_y_i     (in_i.pos_y),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .height_o    (out_o.height),
    .tile_ready_o(out_o.tile_ready)
  );

endmodule
